@@ hw/rtl/escaped_frame_checker_defines.svh @@
// Assertion macros shared by the frame checker RTL.
`ifndef ESCAPED_FRAME_CHECKER_DEFINES_SVH
`define ESCAPED_FRAME_CHECKER_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define EFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising clock edge, also during reset.
`define EFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/efc_pkg.sv @@
package efc_pkg;

	localparam logic [7:0] FLIP_MASK = 8'h20;
	localparam logic [2:0] MIN_BODY  = 3'd4;
	localparam logic [2:0] POS_MAX   = 3'd7;

	localparam logic [7:0] ESCAPE_RESET  = 8'd125;
	localparam logic [7:0] END_RESET     = 8'd126;
	localparam logic [7:0] ADDRESS_RESET = 8'd0;

	localparam logic [1:0] REG_ESCAPE  = 2'd0;
	localparam logic [1:0] REG_END     = 2'd1;
	localparam logic [1:0] REG_ADDRESS = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_CHECKSUM  = 2'd1,
		STAT_ADDRESS   = 2'd2,
		STAT_MALFORMED = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] escape_value;
		logic [7:0] end_value;
		logic [7:0] expected_address;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] decoded_byte;
		logic       decoded_last;
		status_t    frame_status;
	} result_t;

endpackage

@@ hw/rtl/efc_cfg.sv @@
module efc_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_wdata,
	output efc_pkg::cfg_t    cfg
);

	efc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_value     <= efc_pkg::ESCAPE_RESET;
			cfg_q.end_value        <= efc_pkg::END_RESET;
			cfg_q.expected_address <= efc_pkg::ADDRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				efc_pkg::REG_ESCAPE:  cfg_q.escape_value     <= cfg_wdata;
				efc_pkg::REG_END:     cfg_q.end_value        <= cfg_wdata;
				efc_pkg::REG_ADDRESS: cfg_q.expected_address <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/efc_unstuff.sv @@
module efc_unstuff (
	input  logic                clk,
	input  logic                arst_n,
	input  efc_pkg::cfg_t       cfg,
	input  logic                advance,
	input  logic [7:0]          raw_byte,
	input  logic                frame_last,
	output efc_pkg::result_t    res
);

	logic [2:0] pos_q;
	logic       esc_q;
	logic [7:0] par_q;
	logic       addr_ok_q;

	logic [2:0] pos_d;
	logic       esc_d;
	logic [7:0] par_d;
	logic       addr_ok_d;
	logic [7:0] data;
	logic       take;

	always_comb begin
		pos_d     = pos_q;
		esc_d     = esc_q;
		par_d     = par_q;
		addr_ok_d = addr_ok_q;
		data      = raw_byte;
		take      = 1'b1;
		res.valid        = 1'b1;
		res.decoded_byte = raw_byte;
		res.decoded_last = 1'b0;
		res.frame_status = efc_pkg::STAT_OK;

		if (frame_last) begin
			take             = 1'b0;
			res.decoded_byte = cfg.end_value;
			res.decoded_last = 1'b1;
			if (esc_q || pos_q < efc_pkg::MIN_BODY) begin
				res.frame_status = efc_pkg::STAT_MALFORMED;
			end else if (par_q != 8'd0) begin
				res.frame_status = efc_pkg::STAT_CHECKSUM;
			end else if (!addr_ok_q) begin
				res.frame_status = efc_pkg::STAT_ADDRESS;
			end
			pos_d     = 3'd0;
			esc_d     = 1'b0;
			par_d     = 8'd0;
			addr_ok_d = 1'b0;
		end else if (pos_q == 3'd0) begin
			data = raw_byte;
		end else if (esc_q) begin
			data  = raw_byte ^ efc_pkg::FLIP_MASK;
			esc_d = 1'b0;
		end else if (raw_byte == cfg.escape_value) begin
			esc_d     = 1'b1;
			take      = 1'b0;
			res.valid = 1'b0;
		end

		if (take) begin
			res.decoded_byte = data;
			if (pos_q != 3'd0) begin
				par_d = par_q ^ data;
			end
			if (pos_q == 3'd3) begin
				addr_ok_d = (data == cfg.expected_address);
			end
			if (pos_q != efc_pkg::POS_MAX) begin
				pos_d = pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			esc_q     <= 1'b0;
			par_q     <= 8'd0;
			addr_ok_q <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_d;
			esc_q     <= esc_d;
			par_q     <= par_d;
			addr_ok_q <= addr_ok_d;
		end
	end

endmodule

@@ hw/rtl/escaped_frame_checker.sv @@
// Escaped frame checker: takes one raw byte per beat (tlast on the final raw
// byte of a frame) and returns the unstuffed frame, with the configured end
// byte in place of the final raw byte and the frame status in tuser on that
// beat. A beat is accepted in every cycle while the output is drained; a byte
// reaches the output through the input register and then the result register.
// An escape byte produces no output beat. The user must write configuration
// only while no frame byte is in flight; the block does not enforce this.
`include "escaped_frame_checker_defines.svh"

module escaped_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // raw_byte
	input  logic       s_tlast,   // frame_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // decoded_byte
	output logic       m_tlast,   // decoded_last
	output logic [1:0] m_tuser    // frame_status
);

	efc_pkg::cfg_t    cfg;
	efc_pkg::result_t res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	logic [7:0] byte_s2;
	logic       last_s2;
	logic [1:0] status_s2;
	logic       advance;

	efc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	efc_unstuff u_unstuff (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.advance    (advance),
		.raw_byte   (byte_s1),
		.frame_last (last_s1),
		.res        (res)
	);

	assign advance  = valid_s1 && (!res.valid || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			byte_s2   <= res.decoded_byte;
			last_s2   <= res.decoded_last;
			status_s2 <= res.frame_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = byte_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = status_s2;

	`EFC_ASSERT(a_result_loaded, advance && res.valid |=> valid_s2 && (byte_s2 == $past(res.decoded_byte)), "result beat not loaded into the output register")
	`EFC_ASSERT(a_end_follows_last, advance && last_s1 |=> valid_s2 && last_s2, "final raw byte did not produce an end beat")
	`EFC_ASSERT(a_inner_status_ok, valid_s2 && !last_s2 |-> status_s2 == efc_pkg::STAT_OK, "inner beat carries a nonzero status")
	`EFC_ASSERT(a_held_input, valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(last_s1), "stalled input byte was lost")
	`EFC_ASSERT_ALWAYS(a_no_overwrite, valid_s2 && !m_tready |-> !(advance && res.valid), "output beat overwritten while stalled")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import efc_pkg::*;

	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 80;
	localparam int         PHASE_BEATS = 160;
	localparam int         PHASES      = 5;

	typedef struct {
		logic [7:0] data;
		logic       last;
		status_t    status;
	} frame_beat_t;

	typedef struct {
		logic [7:0] raw;
		logic       last;
		bit         fixed;
		logic [7:0] want_byte;
		status_t    want_status;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	logic [7:0] esc_code;
	logic [7:0] end_code;
	logic [7:0] dev_addr;
	logic [2:0] byte_index;
	logic       escape_seen;
	logic [7:0] xor_acc;
	logic       addr_ok;

	frame_beat_t pending_beats[$];
	frame_beat_t seen_want;
	frame_beat_t unused_beat;
	stim_row_t   stim_table[$];

	int unsigned error_count;
	int unsigned beats_checked;
	int unsigned raw_beats;
	int unsigned settings;
	int unsigned by_status[4];
	bit          calm;
	bit          hold_req;

	escaped_frame_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 100) begin
			$display("mismatch after %0d checked beats: %s got 0x%0h want 0x%0h",
				beats_checked, what, got, want);
		end
	endtask

	task automatic predict_unstuff(input logic [7:0] raw, input logic last,
			output bit produced, output frame_beat_t beat);
		logic [7:0] d;
		produced = 1'b1;
		if (last) begin
			beat.data = end_code;
			beat.last = 1'b1;
			if (escape_seen || byte_index < MIN_BODY)
				beat.status = STAT_MALFORMED;
			else if (xor_acc != 8'd0)
				beat.status = STAT_CHECKSUM;
			else if (!addr_ok)
				beat.status = STAT_ADDRESS;
			else
				beat.status = STAT_OK;
			byte_index  = 3'd0;
			escape_seen = 1'b0;
			xor_acc     = 8'd0;
			addr_ok     = 1'b0;
			return;
		end
		if (byte_index == 3'd0) begin
			d = raw;
		end else if (escape_seen) begin
			d = raw ^ FLIP_MASK;
			escape_seen = 1'b0;
		end else if (raw == esc_code) begin
			escape_seen = 1'b1;
			produced = 1'b0;
			return;
		end else begin
			d = raw;
		end
		if (byte_index >= 3'd1)
			xor_acc = xor_acc ^ d;
		if (byte_index == 3'd3)
			addr_ok = (d == dev_addr);
		if (byte_index < POS_MAX)
			byte_index = byte_index + 3'd1;
		beat.data   = d;
		beat.last   = 1'b0;
		beat.status = STAT_OK;
	endtask

	task automatic send_raw(input logic [7:0] raw, input logic last, input bit fixed,
			input frame_beat_t fixed_beat);
		bit          produced;
		frame_beat_t beat;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_unstuff(raw, last, produced, beat);
		if (produced)
			pending_beats.push_back(fixed ? fixed_beat : beat);
		raw_beats++;
	endtask

	task automatic maybe_gap();
		int n;
		if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 11);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ESCAPE:  esc_code = val;
			REG_END:     end_code = val;
			REG_ADDRESS: dev_addr = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [7:0] esc, input logic [7:0] end_byte,
			input logic [7:0] addr);
		settle();
		write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_END, end_byte);
		write_reg(REG_ADDRESS, addr);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic add_row(input logic [7:0] raw, input logic last, input bit fixed,
			input logic [7:0] want_byte, input status_t want_status);
		stim_row_t row;
		row.raw         = raw;
		row.last        = last;
		row.fixed       = fixed;
		row.want_byte   = want_byte;
		row.want_status = want_status;
		stim_table.push_back(row);
	endtask

	task automatic send_random_frame();
		int         kind;
		int         n;
		int         i;
		logic [7:0] body [0:11];
		logic [7:0] chk;
		kind = $urandom_range(0, 9);
		if (kind == 7) begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++) begin
				maybe_gap();
				send_raw(($urandom_range(0, 3) == 0) ? esc_code : 8'($urandom_range(0, 255)),
					(i == n - 1) || ($urandom_range(0, 9) == 0), 1'b0, unused_beat);
			end
			return;
		end
		if (kind == 8)
			n = $urandom_range(0, 3);
		else if ($urandom_range(0, 4) == 0)
			n = $urandom_range(8, 11);
		else
			n = $urandom_range(4, 7);
		for (i = 0; i < n; i++)
			body[4'(i)] = ($urandom_range(0, 4) == 0) ? esc_code : 8'($urandom_range(0, 255));
		if (n > 3 && $urandom_range(0, 7) != 0)
			body[4'd3] = dev_addr;
		if (n > 1 && $urandom_range(0, 7) != 0) begin
			chk = 8'd0;
			for (i = 1; i < n - 1; i++)
				chk = chk ^ body[4'(i)];
			body[4'(n - 1)] = chk;
		end
		for (i = 0; i < n; i++) begin
			maybe_gap();
			if (i > 0 && (body[4'(i)] == esc_code || $urandom_range(0, 7) == 0)) begin
				send_raw(esc_code, 1'b0, 1'b0, unused_beat);
				maybe_gap();
				send_raw(body[4'(i)] ^ FLIP_MASK, 1'b0, 1'b0, unused_beat);
			end else begin
				send_raw(body[4'(i)], 1'b0, 1'b0, unused_beat);
			end
		end
		if (kind == 9) begin
			maybe_gap();
			send_raw(esc_code, 1'b0, 1'b0, unused_beat);
		end
		maybe_gap();
		send_raw(8'($urandom_range(0, 255)), 1'b1, 1'b0, unused_beat);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_beats.size() == 0) begin
				flag_mismatch("beat with nothing expected", int'(m_tdata), -1);
			end else begin
				seen_want = pending_beats.pop_front();
				if (m_tdata !== seen_want.data)
					flag_mismatch("decoded_byte", int'(m_tdata), int'(seen_want.data));
				if (m_tlast !== seen_want.last)
					flag_mismatch("decoded_last", int'(m_tlast), int'(seen_want.last));
				if (m_tuser !== seen_want.status)
					flag_mismatch("frame_status", int'(m_tuser), int'(seen_want.status));
				if (seen_want.last)
					by_status[seen_want.status]++;
				beats_checked++;
			end
		end
	end

	initial begin : ready_driver
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int          p;
		int          w;
		int unsigned phase_start;
		bit          paused;
		frame_beat_t typed;

		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ESCAPE;
		cfg_wdata = 8'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		s_tlast   = 1'b0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		paused    = 1'b0;
		esc_code    = ESCAPE_RESET;
		end_code    = END_RESET;
		dev_addr    = ADDRESS_RESET;
		byte_index  = 3'd0;
		escape_seen = 1'b0;
		xor_acc     = 8'd0;
		addr_ok     = 1'b0;

		// A lone last byte is a frame with no body.
		add_row(8'h7D, 1'b1, 1'b1, END_RESET, STAT_MALFORMED);
		// The first byte equals the escape value and still passes through.
		add_row(8'h7D, 1'b0, 1'b1, 8'h7D, STAT_OK);
		add_row(8'h11, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h22, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h00, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h33, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'hFF, 1'b1, 1'b1, END_RESET, STAT_OK);
		// Shortest legal body with an escaped byte; the checksum wins over the address.
		add_row(8'h00, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h7D, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h5D, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'hFF, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h01, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h00, 1'b1, 1'b1, END_RESET, STAT_CHECKSUM);
		add_row(8'hFF, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h01, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h02, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h05, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h06, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h80, 1'b1, 1'b1, END_RESET, STAT_ADDRESS);
		// An escape left pending at the last byte makes the frame malformed.
		add_row(8'h00, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h01, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h02, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h03, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h04, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h7D, 1'b0, 1'b0, 8'h00, STAT_OK);
		add_row(8'h7D, 1'b1, 1'b1, END_RESET, STAT_MALFORMED);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings = 1;

		foreach (stim_table[i]) begin
			typed.data   = stim_table[i].want_byte;
			typed.last   = stim_table[i].last;
			typed.status = stim_table[i].want_status;
			maybe_gap();
			send_raw(stim_table[i].raw, stim_table[i].last, stim_table[i].fixed, typed);
		end

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: set_regs(8'h00, 8'hFF, 8'hFF);
				1: set_regs(8'hFF, 8'h00, 8'h00);
				4: set_regs(ESCAPE_RESET, END_RESET, ADDRESS_RESET);
				default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			if (p == 2)
				hold_req = 1'b1;
			if (p == PHASES - 1)
				calm = 1'b1;
			phase_start = raw_beats;
			while (raw_beats - phase_start < PHASE_BEATS) begin
				if (p == 1 && !paused && raw_beats - phase_start >= PHASE_BEATS / 2) begin
					settle();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (w = 0; w < 5000 && pending_beats.size() != 0; w++)
			@(posedge clk);
		if (pending_beats.size() != 0)
			flag_mismatch("beats never delivered", 0, pending_beats.size());
		repeat (10) @(posedge clk);

		$display("Checked %0d decoded beats from %0d raw beats under %0d register settings.",
			beats_checked, raw_beats, settings);
		$display("End beats by status: ok %0d, checksum %0d, address %0d, malformed %0d.",
			by_status[STAT_OK], by_status[STAT_CHECKSUM], by_status[STAT_ADDRESS],
			by_status[STAT_MALFORMED]);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/efc_pkg.sv
hw/rtl/efc_cfg.sv
hw/rtl/efc_unstuff.sv
hw/rtl/escaped_frame_checker.sv
dv/testbench.sv
